// File: rtl/core/aligned_region_splitter_slot_writer_core_macros.svh
// Assertion macros for the aligned region splitter core.
// Taken in by the checker module; no other dependencies.
`ifndef ALIGNED_REGION_SPLITTER_SLOT_WRITER_CORE_MACROS_SVH
`define ALIGNED_REGION_SPLITTER_SLOT_WRITER_CORE_MACROS_SVH

// Implication checked on every rising edge outside reset
`define ARSS_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never hold outside reset
`define ARSS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// File: rtl/core/arss_pkg.sv
// Shared types and constants for the aligned region splitter core.
// No dependencies.
`timescale 1ns / 1ps

package arss_pkg;

    // Default number of range slots
    localparam int SLOT_COUNT_DEF = 16;

    // Stream widths (fields packed from bit 0, tdata padded to whole bytes)
    localparam int S_TDATA_W = 72;   // start_addr, region_size, permission
    localparam int M_TDATA_W = 40;   // slot_index, slot_word
    localparam int M_TUSER_W = 2;    // status

    // Granule exponents: 2 GiB down to 4 KiB, 1 MiB minimum accepted
    localparam logic [4:0] EXP_MAX    = 5'd31;
    localparam logic [4:0] EXP_MIN    = 5'd12;
    localparam logic [4:0] EXP_MIN_OK = 5'd20;

    // Result status codes
    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_NO_GRANULE = 2'd1;
    localparam logic [1:0] STAT_SMALL      = 2'd2;
    localparam logic [1:0] STAT_FULL       = 2'd3;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_OUT
    } t_state;

    // Granule test result
    typedef struct packed {
        logic        fit;
        logic [31:0] chunk;
    } t_gran_res;

endpackage

// File: rtl/core/arss_gran_unit.sv
// Shared granule test: does a 2^exp chunk fit the remaining size and alignment.
// Depends on arss_pkg.
`timescale 1ns / 1ps

module arss_gran_unit (
    input  logic [31:0]          i_addr,
    input  logic [31:0]          i_size,
    input  logic [4:0]           i_exp,
    output arss_pkg::t_gran_res  o_res
);

    logic [31:0] w_chunk;
    logic        w_size_ok;
    logic        w_align_ok;

    // Chunk decode, size compare by shift, alignment by mask
    always_comb begin
        w_chunk    = 32'd1 << i_exp;
        w_size_ok  = (i_size >> i_exp) != 32'd0;
        w_align_ok = (i_addr & (w_chunk - 32'd1)) == 32'd0;
        o_res.fit   = w_size_ok & w_align_ok;
        o_res.chunk = w_chunk;
    end

endmodule

// File: rtl/core/aligned_region_splitter_slot_writer_core.sv
// Search: a chunk is tested one exponent per cycle, from 31 down to 12, and its
//   result shows the cycle after the last test; after a result is taken the next
//   chunk search restarts at 31. A zero-size request is taken but gives no result.
// Throughput: one request at a time; ready again once the last result is taken.
// Reset: synchronous, active low; returns to idle and marks every slot free.
`timescale 1ns / 1ps

module aligned_region_splitter_slot_writer_core #(
    parameter int SLOT_COUNT = arss_pkg::SLOT_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [31:0] start_addr, [63:32] region_size, [65:64] permission
    input  logic [arss_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [3:0] slot_index, [35:4] slot_word
    output logic [arss_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic [arss_pkg::M_TUSER_W-1:0] m_axis_tuser,
    output logic                           m_axis_tlast
);

    localparam int FW = $clog2(SLOT_COUNT + 1);

    arss_pkg::t_state    r_state, n_state;
    logic [FW-1:0]       r_fill, n_fill;
    logic [31:0]         r_addr, n_addr;
    logic [31:0]         r_size, n_size;
    logic [1:0]          r_perm, n_perm;
    logic [4:0]          r_exp, n_exp;
    logic [3:0]          r_idx, n_idx;
    logic [31:0]         r_word, n_word;
    logic [1:0]          r_status, n_status;
    logic                r_last, n_last;

    arss_pkg::t_gran_res w_gran;
    logic [FW+3:0]       w_fill_ext;
    logic                w_full;
    logic [31:0]         w_size_left;
    logic [4:0]          w_code;

    // Shared granule tester
    arss_gran_unit u_gran (
        .i_addr (r_addr),
        .i_size (r_size),
        .i_exp  (r_exp),
        .o_res  (w_gran)
    );

    // Slots fill in order, so the lowest free slot is the fill count
    assign w_fill_ext  = {4'b0000, r_fill};
    assign w_full      = r_fill == FW'(SLOT_COUNT);
    assign w_size_left = r_size - w_gran.chunk;
    assign w_code      = r_exp - arss_pkg::EXP_MIN;

    // State register and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= arss_pkg::S_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
        end
    end

    // Working and output payload
    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_size   <= n_size;
        r_perm   <= n_perm;
        r_exp    <= n_exp;
        r_idx    <= n_idx;
        r_word   <= n_word;
        r_status <= n_status;
        r_last   <= n_last;
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_addr   = r_addr;
        n_size   = r_size;
        n_perm   = r_perm;
        n_exp    = r_exp;
        n_idx    = r_idx;
        n_word   = r_word;
        n_status = r_status;
        n_last   = r_last;
        unique case (r_state)
            arss_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_addr = s_axis_tdata[31:0];
                    n_size = s_axis_tdata[63:32];
                    n_perm = s_axis_tdata[65:64];
                    n_exp  = arss_pkg::EXP_MAX;
                    if (s_axis_tdata[63:32] != 32'd0) begin
                        n_state = arss_pkg::S_SEARCH;
                    end
                end
            end
            arss_pkg::S_SEARCH: begin
                // error results carry zero index and word and end the request
                n_idx  = 4'd0;
                n_word = 32'd0;
                n_last = 1'b1;
                if (w_gran.fit) begin
                    n_state = arss_pkg::S_OUT;
                    if (r_exp < arss_pkg::EXP_MIN_OK) begin
                        n_status = arss_pkg::STAT_SMALL;
                    end else if (w_full) begin
                        n_status = arss_pkg::STAT_FULL;
                    end else begin
                        // fresh slot: range enable and undefined-range bits stay clear
                        n_status = arss_pkg::STAT_OK;
                        n_idx    = w_fill_ext[3:0];
                        n_word   = {r_addr[31:12], w_code, 4'b0000, r_perm, 1'b1};
                        n_last   = w_size_left == 32'd0;
                        n_addr   = r_addr + w_gran.chunk;
                        n_size   = w_size_left;
                        n_fill   = r_fill + FW'(1);
                    end
                end else if (r_exp == arss_pkg::EXP_MIN) begin
                    n_status = arss_pkg::STAT_NO_GRANULE;
                    n_state  = arss_pkg::S_OUT;
                end else begin
                    n_exp = r_exp - 5'd1;
                end
            end
            arss_pkg::S_OUT: begin
                if (m_axis_tready) begin
                    n_exp   = arss_pkg::EXP_MAX;
                    n_state = r_last ? arss_pkg::S_IDLE : arss_pkg::S_SEARCH;
                end
            end
            default: begin
                n_state = arss_pkg::S_IDLE;
            end
        endcase
    end

    // Ports
    assign s_axis_tready = r_state == arss_pkg::S_IDLE;
    assign m_axis_tvalid = r_state == arss_pkg::S_OUT;
    assign m_axis_tdata  = {4'b0000, r_word, r_idx};
    assign m_axis_tuser  = r_status;
    assign m_axis_tlast  = r_last;

endmodule

// File: rtl/core/arss_checker.sv
// Port-level checks for the aligned region splitter core, bound to the top level.
// Depends on arss_pkg and the macros header.
`timescale 1ns / 1ps
`include "aligned_region_splitter_slot_writer_core_macros.svh"

module arss_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [arss_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [arss_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [arss_pkg::M_TUSER_W-1:0] m_axis_tuser,
    input logic                           m_axis_tlast
);

    // A pending result holds until taken
    `ARSS_ASSERT_IMPL(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result request dropped while stalled")

    // One request at a time: no new request while a result is shown
    `ARSS_ASSERT_NEVER(a_one_at_a_time, i_clk, i_rst_n, s_axis_tready && m_axis_tvalid, "input ready while a result is pending")

    // Errors end the request and carry no slot
    `ARSS_ASSERT_IMPL(a_err_last, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser != arss_pkg::STAT_OK) |-> m_axis_tlast && (m_axis_tdata == '0), "error result not final or not empty")

    // A written slot word always has its valid bit set
    `ARSS_ASSERT_IMPL(a_ok_valid, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser == arss_pkg::STAT_OK) |-> m_axis_tdata[4], "slot word written without valid bit")

endmodule

bind aligned_region_splitter_slot_writer_core arss_checker u_arss_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
